/* rtl/core/assert_macros.svh */
// Assertion macros for the queue RTL.
// Files that check their own logic include this header by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while reset is released.
`define FQS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, during reset too.
`define FQS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/fqs_pkg.sv */
// Shared types and codes for the FIFO queue with search.
// No dependencies; the top module and fqs_out import this package.
package fqs_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_LIST   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] data;
        logic        [5:0]  position;
        logic        [6:0]  count;
        logic               last;
    } t_result;

endpackage

/* rtl/core/fifo_queue_with_search_top.sv */
// Bounded FIFO of signed 32-bit values held in a ring memory addressed from a head pointer.
// Insert, remove and any command on an empty queue give one result item each.
// Search reads the held entries from the head, one per cycle through the memory's single read
// port, and stops at the first match; a miss ends the walk after the last held entry. List gives
// one item per held entry at one per cycle while the consumer is ready. One command is
// worked on at a time; the next is accepted once the walk is over and the output register can
// take a result, so a consumer that holds off stalls both the walk and the input.
// Depends on fqs_pkg, fqs_store, fqs_out and assert_macros.svh.
module fifo_queue_with_search_top #(
    parameter int DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  fqs_pkg::t_cmd         i_cmd,
    input  logic signed [31:0]    i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output fqs_pkg::t_status      o_status,
    output logic signed [31:0]    o_data,
    output logic [5:0]            o_position,
    output logic [6:0]            o_count,
    output logic                  o_last
);
    import fqs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [6:0]  DEPTH_C = 7'(DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [6:0]         r_count, n_count;
    t_cmd               r_cmd, n_cmd;
    logic signed [31:0] r_key, n_key;
    logic [6:0]         r_idx, n_idx;
    logic               r_rd_vld, n_rd_vld;
    logic [5:0]         r_rd_pos, n_rd_pos;

    logic               w_acc;
    logic               w_done;
    logic               w_out_free;
    logic               w_load;
    t_result            w_res;
    t_result            w_out_res;
    logic               w_wr_en;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic signed [31:0] w_rd_data;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [6:0] off);
        logic [AW:0] sum;
        sum = (AW + 1)'(head) + (AW + 1)'(off[AW-1:0]);
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    fqs_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (slot_of(r_head, r_count)),
        .i_wr_data (i_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    fqs_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (w_out_res)
    );

    assign o_status   = w_out_res.status;
    assign o_data     = w_out_res.data;
    assign o_position = w_out_res.position;
    assign o_count    = w_out_res.count;
    assign o_last     = w_out_res.last;

    assign o_ready = (r_state == S_IDLE) && w_out_free;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && r_count != 7'd0
                    && (i_cmd == CMD_SEARCH || i_cmd == CMD_LIST)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        logic hit;
        logic end_pos;
        logic consume;
        logic issue;

        hit      = (w_rd_data == r_key);
        end_pos  = ((7'(r_rd_pos) + 7'd1) == r_count);
        consume  = 1'b0;
        issue    = 1'b0;
        w_done   = 1'b0;
        w_load   = 1'b0;
        w_res    = '0;
        w_wr_en  = 1'b0;
        w_rd_en  = 1'b0;
        w_rd_addr = slot_of(r_head, r_idx);
        n_head   = r_head;
        n_count  = r_count;
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_idx    = r_idx;
        n_rd_vld = r_rd_vld;
        n_rd_pos = r_rd_pos;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    w_res.last = 1'b1;
                    unique case (i_cmd) inside
                        CMD_INSERT: begin
                            w_load = 1'b1;
                            if (r_count < DEPTH_C) begin
                                w_wr_en       = 1'b1;
                                n_count       = r_count + 7'd1;
                                w_res.status  = ST_OK;
                            end else begin
                                w_res.status  = ST_FULL;
                            end
                        end
                        CMD_REMOVE: begin
                            w_load = 1'b1;
                            if (r_count == 7'd0) begin
                                w_res.status = ST_EMPTY;
                            end else begin
                                n_head       = slot_of(r_head, 7'd1);
                                n_count      = r_count - 7'd1;
                                w_res.status = ST_OK;
                            end
                        end
                        CMD_SEARCH, CMD_LIST: begin
                            if (r_count == 7'd0) begin
                                w_load       = 1'b1;
                                w_res.status = ST_EMPTY;
                            end else begin
                                n_cmd    = i_cmd;
                                n_key    = i_value;
                                n_idx    = 7'd0;
                                n_rd_vld = 1'b0;
                            end
                        end
                    endcase
                    w_res.count = n_count;
                end
            end
            S_WALK: begin
                // The registered read data is the one stage of the walk; it holds
                // until its result can go to the output register.
                if (r_rd_vld) begin
                    w_res.count    = r_count;
                    w_res.data     = w_rd_data;
                    w_res.position = r_rd_pos;
                    if (r_cmd == CMD_LIST) begin
                        if (w_out_free) begin
                            w_load       = 1'b1;
                            w_res.status = ST_OK;
                            w_res.last   = end_pos;
                            consume      = 1'b1;
                            w_done       = end_pos;
                        end
                    end else if (hit || end_pos) begin
                        if (w_out_free) begin
                            w_load     = 1'b1;
                            w_res.last = 1'b1;
                            consume    = 1'b1;
                            w_done     = 1'b1;
                            if (hit) begin
                                w_res.status = ST_OK;
                            end else begin
                                w_res.status   = ST_NOTFOUND;
                                w_res.data     = '0;
                                w_res.position = '0;
                            end
                        end
                    end else begin
                        consume = 1'b1;
                    end
                end
                issue = (!r_rd_vld || consume) && !w_done && (r_idx < r_count);
                if (issue) begin
                    w_rd_en  = 1'b1;
                    n_rd_pos = r_idx[5:0];
                    n_idx    = r_idx + 7'd1;
                end
                if (issue) begin
                    n_rd_vld = 1'b1;
                end else if (consume) begin
                    n_rd_vld = 1'b0;
                end
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_rd_pos <= n_rd_pos;
    end

    `include "assert_macros.svh"

    `FQS_ASSERT_RST(a_count_bound, r_count <= DEPTH_C, "entry count exceeds depth")
    `FQS_ASSERT_RST(a_stage_in_walk, r_rd_vld |-> r_state == S_WALK,
                    "read stage valid outside walk")
    `FQS_ASSERT_RST(a_insert_grows,
                    (w_acc && i_cmd == CMD_INSERT && r_count < DEPTH_C)
                    |=> r_count == $past(r_count) + 7'd1,
                    "insert did not grow the queue")
    `FQS_ASSERT_RST(a_walk_no_write, r_state == S_WALK |-> !w_wr_en,
                    "memory written during a walk")

endmodule

/* rtl/core/fqs_store.sv */
// Entry memory of the queue: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module fqs_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic signed [31:0]    i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output logic signed [31:0]    o_rd_data
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds while no read is issued, so it doubles as a stall stage.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/fqs_out.sv */
// Output register of the queue: holds one result item until the consumer takes it.
// Depends on fqs_pkg for the result type.
module fqs_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  fqs_pkg::t_result  i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output fqs_pkg::t_result  o_res
);
    import fqs_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

/* verif/fifo_queue_with_search_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for fifo_queue_with_search_top: drives insert, search, remove and
// list commands with random idling on both sides and checks every result item against a
// scoreboard that keeps its own copy of the queue. Depends on fqs_pkg and the block's RTL.
module fifo_queue_with_search_top_test;
    import fqs_pkg::*;

    localparam int          QUEUE_SLOTS = 64;
    localparam int          ITEM_TARGET = 350;
    localparam int unsigned CYCLE_LIMIT = 10_000_000;

    // Keeps a shadow of the queue contents and the result items each command must produce.
    class queue_scoreboard;
        logic signed [31:0] held [QUEUE_SLOTS];
        int unsigned        head_ptr;
        int unsigned        held_count;
        t_result            expected_q[$];
        int unsigned        mismatches;
        int unsigned        results_checked;
        int unsigned        cmd_seen [4];
        int unsigned        status_seen [4];

        function new();
            head_ptr = 0;
            held_count = 0;
            mismatches = 0;
            results_checked = 0;
            foreach (cmd_seen[i]) cmd_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function logic signed [31:0] held_at(int unsigned offset);
            return held[(head_ptr + offset) % QUEUE_SLOTS];
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        function void push_expected(t_status s, logic signed [31:0] d, int unsigned pos,
                                    bit fin);
            t_result r;
            r.status   = s;
            r.data     = d;
            r.position = pos[5:0];
            r.count    = held_count[6:0];
            r.last     = fin;
            expected_q.push_back(r);
            status_seen[int'(s)]++;
        endfunction

        function void note_command(t_cmd c, logic signed [31:0] v);
            int unsigned offset;
            bit          hit;
            cmd_seen[int'(c)]++;
            case (c)
                CMD_INSERT: begin
                    if (held_count < QUEUE_SLOTS) begin
                        held[(head_ptr + held_count) % QUEUE_SLOTS] = v;
                        held_count++;
                        push_expected(ST_OK, 0, 0, 1'b1);
                    end else begin
                        push_expected(ST_FULL, 0, 0, 1'b1);
                    end
                end
                CMD_SEARCH: begin
                    if (held_count == 0) begin
                        push_expected(ST_EMPTY, 0, 0, 1'b1);
                    end else begin
                        hit = 1'b0;
                        for (offset = 0; offset < held_count && !hit; offset++) begin
                            if (held_at(offset) == v) begin
                                push_expected(ST_OK, v, offset, 1'b1);
                                hit = 1'b1;
                            end
                        end
                        if (!hit) push_expected(ST_NOTFOUND, 0, 0, 1'b1);
                    end
                end
                CMD_REMOVE: begin
                    if (held_count == 0) begin
                        push_expected(ST_EMPTY, 0, 0, 1'b1);
                    end else begin
                        head_ptr = (head_ptr + 1) % QUEUE_SLOTS;
                        held_count--;
                        push_expected(ST_OK, 0, 0, 1'b1);
                    end
                end
                default: begin
                    if (held_count == 0) begin
                        push_expected(ST_EMPTY, 0, 0, 1'b1);
                    end else begin
                        for (offset = 0; offset < held_count; offset++)
                            push_expected(ST_OK, held_at(offset), offset,
                                          offset + 1 == held_count);
                    end
                end
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            results_checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result item with nothing expected: status %0d data %0d",
                             $realtime, got.status, got.data);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.data !== want.data ||
                got.position !== want.position || got.count !== want.count ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch, expected status %0d data %0d pos %0d count %0d last %0d",
                             $realtime, want.status, want.data, want.position, want.count,
                             want.last);
                    $display("%0t:           actual   status %0d data %0d pos %0d count %0d last %0d",
                             $realtime, got.status, got.data, got.position, got.count,
                             got.last);
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    t_cmd               i_cmd;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic               i_ready;
    t_status            o_status;
    logic signed [31:0] o_data;
    logic [5:0]         o_position;
    logic [6:0]         o_count;
    logic               o_last;

    queue_scoreboard sb = new();
    int unsigned     sent_total = 0;
    int unsigned     cycle_count = 0;
    int unsigned     rx_stall = 0;
    bit              rx_calm = 1'b0;
    bit              rx_hold_req = 1'b0;
    bit              tx_calm = 1'b0;
    t_result         rx_item;

    fifo_queue_with_search_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cmd      (i_cmd),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_data     (o_data),
        .o_position (o_position),
        .o_count    (o_count),
        .o_last     (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Small values give duplicates, so searches must find the first of several copies.
    function automatic logic signed [31:0] rand_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) return int'($urandom_range(0, 15)) - 8;
        if (r < 45) begin
            case ($urandom_range(0, 4))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sh0000_0000;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic signed [31:0] search_key();
        if (sb.held_count != 0 && $urandom_range(0, 9) < 7)
            return sb.held_at($urandom_range(0, sb.held_count - 1));
        return rand_value();
    endfunction

    task automatic issue_cmd(input t_cmd c, input logic signed [31:0] v);
        int unsigned gap;
        i_valid <= 1'b1;
        i_cmd   <= c;
        i_value <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_command(c, v);
        sent_total++;
        gap = tx_calm ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Fill up past full; the head has moved by now, so the ring wraps.
    task automatic fill_phase();
        tx_calm = ($urandom_range(0, 3) == 0);
        while (sb.held_count < QUEUE_SLOTS) begin
            if ($urandom_range(0, 9) == 0) issue_cmd(CMD_SEARCH, search_key());
            else issue_cmd(CMD_INSERT, rand_value());
        end
        issue_cmd(CMD_INSERT, rand_value());
        issue_cmd(CMD_INSERT, rand_value());
        issue_cmd(CMD_SEARCH, sb.held_at(QUEUE_SLOTS - 1));
        issue_cmd(CMD_LIST, rand_value());
    endtask

    task automatic mixed_phase(input int unsigned n);
        int unsigned r;
        tx_calm = ($urandom_range(0, 3) == 0);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 35) issue_cmd(CMD_INSERT, rand_value());
            else if (r < 65) issue_cmd(CMD_SEARCH, search_key());
            else if (r < 90) issue_cmd(CMD_REMOVE, rand_value());
            else issue_cmd(CMD_LIST, rand_value());
        end
    endtask

    task automatic drain_phase();
        int unsigned r;
        tx_calm = ($urandom_range(0, 3) == 0);
        while (sb.held_count != 0) begin
            r = $urandom_range(0, 99);
            if (r < 85) issue_cmd(CMD_REMOVE, rand_value());
            else if (r < 95) issue_cmd(CMD_SEARCH, search_key());
            else issue_cmd(CMD_LIST, rand_value());
        end
        issue_cmd(CMD_REMOVE, rand_value());
        issue_cmd(CMD_SEARCH, rand_value());
        issue_cmd(CMD_LIST, rand_value());
    endtask

    // Result side: check accepted items, then choose the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            rx_item.status   = o_status;
            rx_item.data     = o_data;
            rx_item.position = o_position;
            rx_item.count    = o_count;
            rx_item.last     = o_last;
            sb.check_result(rx_item);
        end
        if (cycle_count % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        if (rx_hold_req) begin
            rx_stall = 500;
            rx_hold_req = 1'b0;
        end
        if (rx_stall != 0) begin
            i_ready <= 1'b0;
            rx_stall--;
        end else begin
            i_ready <= 1'b1;
            if (!rx_calm) rx_stall = pick_gap();
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d result items outstanding",
                 cycle_count, sb.outstanding());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_cmd   = CMD_INSERT;
        i_value = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue behavior, extreme values, duplicates and a moved head.
        issue_cmd(CMD_SEARCH, 32'sd5);
        issue_cmd(CMD_REMOVE, 32'sd0);
        issue_cmd(CMD_LIST, 32'sd0);
        issue_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
        issue_cmd(CMD_INSERT, 32'sh8000_0000);
        issue_cmd(CMD_INSERT, 32'sh0000_0000);
        issue_cmd(CMD_INSERT, -32'sd1);
        issue_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
        issue_cmd(CMD_SEARCH, 32'sh7FFF_FFFF);
        issue_cmd(CMD_SEARCH, -32'sd1);
        issue_cmd(CMD_SEARCH, 32'sh8000_0000);
        issue_cmd(CMD_SEARCH, 32'sd12345);
        issue_cmd(CMD_LIST, 32'sd0);
        issue_cmd(CMD_REMOVE, 32'sd0);
        issue_cmd(CMD_SEARCH, 32'sh7FFF_FFFF);
        issue_cmd(CMD_LIST, 32'sd0);
        repeat (4) issue_cmd(CMD_REMOVE, 32'sd0);
        issue_cmd(CMD_LIST, 32'sd0);
        issue_cmd(CMD_INSERT, 32'sh5555_5555);
        issue_cmd(CMD_INSERT, 32'shAAAA_AAAA);
        issue_cmd(CMD_SEARCH, 32'shAAAA_AAAA);
        wait_drained();

        fill_phase();
        wait_drained();
        // The result side stops for a long stretch while commands keep coming.
        rx_hold_req = 1'b1;
        mixed_phase(80);
        wait_drained();
        drain_phase();
        wait_drained();
        while (sent_total < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0) fill_phase();
            else mixed_phase(40);
            wait_drained();
        end
        repeat (80) @(posedge i_clk);

        $display("Ran %0d commands (insert %0d, search %0d, remove %0d, list %0d), %0d results",
                 sent_total, sb.cmd_seen[0], sb.cmd_seen[1], sb.cmd_seen[2], sb.cmd_seen[3],
                 sb.results_checked);
        $display("Expected statuses: ok %0d, full %0d, empty %0d, not found %0d; %0d mismatches",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
